### hdl/evr_pkg.sv
package evr_pkg;

	// Field widths
	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_WIDTH = 16;

	// Internal formats
	localparam int PHASE_WIDTH  = 32;
	localparam int INT_WIDTH    = COORD_WIDTH + 4;
	localparam int TRIG_WIDTH   = 33;
	localparam int RES_WIDTH    = 34;
	localparam int FRAC_BITS    = 30;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int ROT_LAT      = 2;
	localparam int PIPE_LAT     = CORDIC_LAT + 3 * ROT_LAT + 1;
	localparam int GAIN_Q30     = 652032874;

	typedef logic signed [INT_WIDTH-1:0]   coord_t;
	typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
	typedef logic signed [RES_WIDTH-1:0]   resid_t;
	typedef logic        [ANGLE_WIDTH-1:0] ang_t;

	// Arctangent of 2^-i, full turn = 2^32
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

### hdl/evr_cordic.sv
module evr_cordic import evr_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  ang_t  angle,
	output trig_t sin_val,
	output trig_t cos_val
);

	trig_t  x_s [CORDIC_STEPS+1];
	trig_t  y_s [CORDIC_STEPS+1];
	resid_t z_s [CORDIC_STEPS+1];
	logic   flip_s [CORDIC_STEPS+1];
	trig_t  sin_s;
	trig_t  cos_s;

	logic [PHASE_WIDTH-1:0] phase;
	logic [PHASE_WIDTH-1:0] resid;
	logic                   flip;

	// Fold the second and third quadrants onto the first and fourth
	always_comb begin
		phase = {angle, {(PHASE_WIDTH-ANGLE_WIDTH){1'b0}}};
		flip  = phase[PHASE_WIDTH-1] ^ phase[PHASE_WIDTH-2];
		resid = {phase[PHASE_WIDTH-1] ^ flip, phase[PHASE_WIDTH-2:0]};
	end

	// Load the start vector
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= TRIG_WIDTH'(GAIN_Q30);
			y_s[0]    <= '0;
			z_s[0]    <= RES_WIDTH'(signed'(resid));
			flip_s[0] <= flip;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][RES_WIDTH-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - signed'(RES_WIDTH'(ATAN_TURNS[i]));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + signed'(RES_WIDTH'(ATAN_TURNS[i]));
				end
			end
		end
	end

	// Undo the quadrant fold
	always_ff @(posedge clk) begin
		if (en) begin
			cos_s <= flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
			sin_s <= flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
		end
	end

	assign sin_val = sin_s;
	assign cos_val = cos_s;

endmodule

### hdl/evr_rot.sv
module evr_rot import evr_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  coord_t a,
	input  coord_t b,
	input  trig_t  s,
	input  trig_t  c,
	output coord_t a_rot,
	output coord_t b_rot
);

	localparam int PW = INT_WIDTH + TRIG_WIDTH;

	logic [INT_WIDTH-1:0]  a_mag, b_mag;
	logic [TRIG_WIDTH-1:0] s_mag, c_mag;
	logic [PW-1:0] ac_s1, bs_s1, as_s1, bc_s1;
	logic          ac_neg_s1, bs_neg_s1, as_neg_s1, bc_neg_s1;
	coord_t        ac, bs, as_v, bc;
	coord_t        a_s2, b_s2;

	function automatic coord_t round_q30(input logic [PW-1:0] p, input logic neg);
		logic [PW-1:0]        t;
		logic [INT_WIDTH-1:0] r;
		t = p + {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
		r = INT_WIDTH'(t >> FRAC_BITS);
		return neg ? -signed'(r) : signed'(r);
	endfunction

	// Take magnitudes
	always_comb begin
		a_mag = a[INT_WIDTH-1] ? unsigned'(-a) : unsigned'(a);
		b_mag = b[INT_WIDTH-1] ? unsigned'(-b) : unsigned'(b);
		s_mag = s[TRIG_WIDTH-1] ? unsigned'(-s) : unsigned'(s);
		c_mag = c[TRIG_WIDTH-1] ? unsigned'(-c) : unsigned'(c);
	end

	// Multiply magnitudes, keep the product signs
	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1     <= PW'(a_mag) * PW'(c_mag);
			bs_s1     <= PW'(b_mag) * PW'(s_mag);
			as_s1     <= PW'(a_mag) * PW'(s_mag);
			bc_s1     <= PW'(b_mag) * PW'(c_mag);
			ac_neg_s1 <= a[INT_WIDTH-1] ^ c[TRIG_WIDTH-1];
			bs_neg_s1 <= b[INT_WIDTH-1] ^ s[TRIG_WIDTH-1];
			as_neg_s1 <= a[INT_WIDTH-1] ^ s[TRIG_WIDTH-1];
			bc_neg_s1 <= b[INT_WIDTH-1] ^ c[TRIG_WIDTH-1];
		end
	end

	// Round each product half away from zero
	always_comb begin
		ac   = round_q30(ac_s1, ac_neg_s1);
		bs   = round_q30(bs_s1, bs_neg_s1);
		as_v = round_q30(as_s1, as_neg_s1);
		bc   = round_q30(bc_s1, bc_neg_s1);
	end

	// Combine into the rotated pair
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= ac - bs;
			b_s2 <= as_v + bc;
		end
	end

	assign a_rot = a_s2;
	assign b_rot = b_s2;

endmodule

### hdl/euler_xyz_vector_rotate.sv
// An accepted point passes the CORDIC stages, the rotations about X, Y and Z, and the clip register.
// Throughput: one point per cycle unless stalled; the three CORDIC pipelines run side by side.
// The whole pipeline holds only while the final stage keeps an untaken result.
// Reset clears the stage valid bits only; data registers are not reset.
module euler_xyz_vector_rotate import evr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  ang_t                          angle_about_x,
	input  ang_t                          angle_about_y,
	input  ang_t                          angle_about_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] rot_x,
	output logic signed [COORD_WIDTH-1:0] rot_y,
	output logic signed [COORD_WIDTH-1:0] rot_z,
	output logic                          saturated
);

	localparam int LAST = CORDIC_LAT - 1;

	logic en;
	logic [PIPE_LAT-1:0] v_s;

	logic signed [COORD_WIDTH-1:0] px_s [CORDIC_LAT];
	logic signed [COORD_WIDTH-1:0] py_s [CORDIC_LAT];
	logic signed [COORD_WIDTH-1:0] pz_s [CORDIC_LAT];

	trig_t sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
	trig_t sy_s [ROT_LAT];
	trig_t cy_s [ROT_LAT];
	trig_t sz_s [2*ROT_LAT];
	trig_t cz_s [2*ROT_LAT];

	coord_t y1, z1, z2, x2, x3, y3;
	coord_t xd1_s [ROT_LAT];
	coord_t yd2_s [ROT_LAT];
	coord_t zd3_s [ROT_LAT];

	logic signed [COORD_WIDTH-1:0] rot_x_s, rot_y_s, rot_z_s;
	logic                          sat_s;

	logic signed [COORD_WIDTH-1:0] cx, cy, cz;
	logic                          fx, fy, fz;

	function automatic logic signed [COORD_WIDTH-1:0] clip(input coord_t v, output logic hit);
		coord_t hi, lo;
		hi = INT_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
		lo = -hi - coord_t'(1);
		hit = (v > hi) || (v < lo);
		if (v > hi)
			return hi[COORD_WIDTH-1:0];
		else if (v < lo)
			return lo[COORD_WIDTH-1:0];
		else
			return v[COORD_WIDTH-1:0];
	endfunction

	// Advance unless the final stage holds a result not yet taken
	assign en        = ~v_s[PIPE_LAT-1] | out_ready;
	assign in_ready  = en;
	assign out_valid = v_s[PIPE_LAT-1];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[PIPE_LAT-2:0], in_valid};
		end
	end

	// Sine and cosine for each axis
	evr_cordic u_cordic_x (.clk, .en, .angle(angle_about_x), .sin_val(sin_x), .cos_val(cos_x));
	evr_cordic u_cordic_y (.clk, .en, .angle(angle_about_y), .sin_val(sin_y), .cos_val(cos_y));
	evr_cordic u_cordic_z (.clk, .en, .angle(angle_about_z), .sin_val(sin_z), .cos_val(cos_z));

	// Hold the coordinates alongside the CORDIC stages
	always_ff @(posedge clk) begin
		if (en) begin
			px_s[0] <= pos_x;
			py_s[0] <= pos_y;
			pz_s[0] <= pos_z;
			for (int k = 1; k < CORDIC_LAT; k++) begin
				px_s[k] <= px_s[k-1];
				py_s[k] <= py_s[k-1];
				pz_s[k] <= pz_s[k-1];
			end
		end
	end

	// Delay the later angles' trig and the untouched coordinate of each rotation
	always_ff @(posedge clk) begin
		if (en) begin
			sy_s[0]  <= sin_y;
			cy_s[0]  <= cos_y;
			sz_s[0]  <= sin_z;
			cz_s[0]  <= cos_z;
			xd1_s[0] <= INT_WIDTH'(px_s[LAST]);
			yd2_s[0] <= y1;
			zd3_s[0] <= z2;
			for (int k = 1; k < ROT_LAT; k++) begin
				sy_s[k]  <= sy_s[k-1];
				cy_s[k]  <= cy_s[k-1];
				xd1_s[k] <= xd1_s[k-1];
				yd2_s[k] <= yd2_s[k-1];
				zd3_s[k] <= zd3_s[k-1];
			end
			for (int k = 1; k < 2*ROT_LAT; k++) begin
				sz_s[k] <= sz_s[k-1];
				cz_s[k] <= cz_s[k-1];
			end
		end
	end

	// About X: y, z
	evr_rot u_rot_x (
		.clk, .en,
		.a(INT_WIDTH'(py_s[LAST])), .b(INT_WIDTH'(pz_s[LAST])),
		.s(sin_x), .c(cos_x),
		.a_rot(y1), .b_rot(z1)
	);

	// About Y: z, x
	evr_rot u_rot_y (
		.clk, .en,
		.a(z1), .b(xd1_s[ROT_LAT-1]),
		.s(sy_s[ROT_LAT-1]), .c(cy_s[ROT_LAT-1]),
		.a_rot(z2), .b_rot(x2)
	);

	// About Z: x, y
	evr_rot u_rot_z (
		.clk, .en,
		.a(x2), .b(yd2_s[ROT_LAT-1]),
		.s(sz_s[2*ROT_LAT-1]), .c(cz_s[2*ROT_LAT-1]),
		.a_rot(x3), .b_rot(y3)
	);

	// Clip to the output range
	always_comb begin
		cx = clip(x3, fx);
		cy = clip(y3, fy);
		cz = clip(zd3_s[ROT_LAT-1], fz);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_x_s <= cx;
			rot_y_s <= cy;
			rot_z_s <= cz;
			sat_s   <= fx | fy | fz;
		end
	end

	assign rot_x     = rot_x_s;
	assign rot_y     = rot_y_s;
	assign rot_z     = rot_z_s;
	assign saturated = sat_s;

endmodule
